FILE: src/hkm_pkg.sv
package hkm_pkg;

  localparam int MaxPointsDef = 1024;
  localparam int CoordBitsDef = 12;
  localparam int CoordW       = 12;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 64;
  localparam int CntW         = 16;
  localparam int ProjW        = 16;
  localparam int IdxW         = 10;
  localparam int RadiusW      = 12;
  localparam int PcountW      = 11;
  localparam int NumW         = 48;   // |num| < 2^47
  localparam int DivW         = 56;   // working width of the divider
  localparam int QuotW        = 17;   // quotient bits worth keeping

  typedef enum logic [1:0] {
    FUNC_STORE = 2'd0,
    FUNC_MATCH = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ZDEN  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_ROW0  = 3'd0,
    CFG_ROW1  = 3'd1,
    CFG_TRANS = 3'd2,
    CFG_PERSP = 3'd3,
    CFG_SCALE = 3'd4,
    CFG_RAD   = 3'd5,
    CFG_PCNT  = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SUM, S_DIVX, S_DIVY, S_SCAN, S_DRAIN, S_OUT
  } state_t;

endpackage

FILE: src/hkm_in_if.sv
interface hkm_in_if;
  import hkm_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [CoordW-1:0] point_x;
  logic [CoordW-1:0] point_y;
  modport source (output valid, func, point_x, point_y, input ready);
  modport sink   (input valid, func, point_x, point_y, output ready);
endinterface

FILE: src/hkm_out_if.sv
interface hkm_out_if;
  import hkm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [ProjW-1:0] proj_x;
  logic signed [ProjW-1:0] proj_y;
  logic                   matched;
  logic [IdxW-1:0]        match_index;
  logic [CntW-1:0]        positive_count;
  logic [CntW-1:0]        evaluated_count;
  logic [1:0]             status;
  modport source (output valid, proj_x, proj_y, matched, match_index, positive_count,
                  evaluated_count, status, input ready);
  modport sink   (input valid, proj_x, proj_y, matched, match_index, positive_count,
                  evaluated_count, status, output ready);
endinterface

FILE: src/hkm_ram.sv
module hkm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/homography_keypoint_match_counter.sv
// Channel | dir | handshake     | payload
// in      | in  | valid/ready   | func, point_x, point_y
// out     | out | valid/ready   | proj_x, proj_y, matched, match_index, counts, status
// cfg     | in  | cfg_we        | cfg_idx, cfg_data
//
// Store, clear and spare transactions pass through S_OUT into the result register;
// a match with a zero denominator passes through S_MUL, S_SUM, S_DIVX and S_OUT.
// Any other match runs multiply, sum, two restoring divisions (QuotW quotient bits
// each), then scans n targets (at most point_count), one per cycle through the read
// address shared by the two target memories, then drains; a hit cuts the scan short.
// Reset is synchronous; the target memories need no clearing pass since only written
// entries are read. A stalled result holds in the output register; the next
// transaction waits until it has been taken.
module homography_keypoint_match_counter
  import hkm_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDef,
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  hkm_in_if.sink              in_ch,
  hkm_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data
);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SW = $clog2(MAX_POINTS + 1);
  localparam logic [CoordW-1:0] CMask = CoordW'((1 << COORD_BITS) - 1);

  // configuration registers
  logic [63:0] row0_r, row1_r, trans_r, persp_r;
  logic [31:0] scale_r;
  logic [RadiusW-1:0] rad_r;
  logic [PcountW-1:0] pcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r <= 64'd16777216; row1_r <= 64'd16777216; trans_r <= '0;
      persp_r <= '0; scale_r <= 32'd16777216; rad_r <= RadiusW'(19); pcnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ROW0:  row0_r  <= cfg_data;
        CFG_ROW1:  row1_r  <= cfg_data;
        CFG_TRANS: trans_r <= cfg_data;
        CFG_PERSP: persp_r <= cfg_data;
        CFG_SCALE: scale_r <= cfg_data[31:0];
        CFG_RAD:   rad_r   <= cfg_data[RadiusW-1:0];
        CFG_PCNT:  pcnt_r  <= cfg_data[PcountW-1:0];
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic [SW-1:0] stored_r;
  logic [CntW-1:0] pos_r, eval_r;
  logic [1:0] func_r;
  logic [CoordW-1:0] x_r, y_r;

  // products, one multiplier per term
  logic signed [NumW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [NumW-1:0] nx_r, ny_r, den_r;

  // divider
  logic [DivW-1:0] rem_r, dd_r, dvd_r;
  logic sat_r;
  logic [QuotW-1:0] q_r;
  logic [5:0] step_r;
  logic negx_r;
  logic signed [ProjW-1:0] px_r, py_r;

  // scan
  logic [SW-1:0] scan_r, lim_r;
  logic rd_v_r;
  logic [AW-1:0] rd_i_r;
  logic hit_r;
  logic [AW-1:0] hit_i_r;

  // result register
  logic ov_r;
  logic signed [ProjW-1:0] o_px_r, o_py_r;
  logic o_m_r;
  logic [IdxW-1:0] o_i_r;
  logic [1:0] o_st_r;

  assign in_ch.ready = (state_r == S_IDLE) && !ov_r;
  wire acc = in_ch.valid && in_ch.ready;

  // target memories
  logic ram_we;
  logic [AW-1:0] waddr, raddr;
  logic [CoordW-1:0] tx, ty;
  assign ram_we = acc && (in_ch.func == FUNC_STORE) && (stored_r < SW'(MAX_POINTS));
  assign waddr  = stored_r[AW-1:0];
  assign raddr  = scan_r[AW-1:0];
  hkm_ram #(.Width(CoordW), .Depth(MAX_POINTS)) u_ram_x (
    .clk, .we(ram_we), .waddr, .wdata(in_ch.point_x & CMask), .raddr, .rdata(tx));
  hkm_ram #(.Width(CoordW), .Depth(MAX_POINTS)) u_ram_y (
    .clk, .we(ram_we), .waddr, .wdata(in_ch.point_y & CMask), .raddr, .rdata(ty));

  // divider helpers
  function automatic logic [DivW-1:0] absn(input logic signed [NumW-1:0] v);
    return DivW'(v[NumW-1] ? -v : v);
  endfunction
  logic div_done, scan_end;
  logic [DivW-1:0] n_abs, d_abs, dvd_init, shifted, trial;
  logic signed [ProjW-1:0] div_res;
  logic [QuotW-1:0] qf;
  assign n_abs    = absn((state_r == S_DIVX) ? nx_r : ny_r);
  assign d_abs    = absn(den_r);
  // dividend 128n + d, divisor 2d
  assign dvd_init = (n_abs << 7) + d_abs;
  // bring down the next dividend bit, then compare and subtract
  assign shifted  = {rem_r[DivW-2:0], dvd_r[QuotW-1]};
  assign trial    = (shifted >= dd_r) ? shifted - dd_r : shifted;
  assign div_done = (step_r == 6'(QuotW));
  // final quotient is floor((128n + d) / 2d); a quotient too wide for QuotW saturates
  assign qf       = sat_r ? '1 : q_r;
  always_comb begin
    if (negx_r) div_res = (qf > QuotW'(32768)) ? -16'sd32768 : -$signed(ProjW'(qf));
    else        div_res = (qf > QuotW'(32767)) ? 16'sd32767 : $signed(ProjW'(qf));
  end

  // distance check on the registered memory output
  logic signed [ProjW:0] dxs, dys;
  logic [ProjW:0] adx, ady, cheb;
  logic near;
  always_comb begin
    dxs  = (ProjW+1)'(px_r) - $signed({5'd0, tx});
    dys  = (ProjW+1)'(py_r) - $signed({5'd0, ty});
    adx  = dxs[ProjW] ? (ProjW+1)'(-dxs) : (ProjW+1)'(dxs);
    ady  = dys[ProjW] ? (ProjW+1)'(-dys) : (ProjW+1)'(dys);
    cheb = (adx > ady) ? adx : ady;
    near = rd_v_r && (cheb < (ProjW+1)'(rad_r));
  end
  assign scan_end = (scan_r >= lim_r) || hit_r || near;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (acc) state_nxt = (in_ch.func == FUNC_MATCH) ? S_MUL : S_OUT;
      S_MUL:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_DIVX;
      S_DIVX:  if (den_r == '0) state_nxt = S_OUT; else if (div_done) state_nxt = S_DIVY;
      S_DIVY:  if (div_done) state_nxt = S_SCAN;
      S_SCAN:  if (scan_r >= lim_r) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // working datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; stored_r <= '0; pos_r <= '0; eval_r <= '0; ov_r <= 1'b0;
      step_r <= '0; hit_r <= 1'b0; rd_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (acc) begin
          func_r <= in_ch.func; x_r <= in_ch.point_x & CMask; y_r <= in_ch.point_y & CMask;
          o_px_r <= '0; o_py_r <= '0; o_m_r <= 1'b0; o_i_r <= '0;
          o_st_r <= (in_ch.func == FUNC_STORE && !ram_we) ? ST_FULL : ST_OK;
          hit_r <= 1'b0; rd_v_r <= 1'b0; step_r <= '0;
          if (in_ch.func == FUNC_STORE) begin
            if (ram_we) stored_r <= stored_r + 1'b1;
          end else if (in_ch.func == FUNC_CLEAR) begin
            stored_r <= '0; pos_r <= '0; eval_r <= '0;
          end else if (in_ch.func == FUNC_MATCH) begin
            if (eval_r != '1) eval_r <= eval_r + 1'b1;
          end
        end
        S_MUL: begin
          p0_r <= NumW'($signed(row0_r[63:32]) * $signed({1'b0, x_r}));
          p1_r <= NumW'($signed(row0_r[31:0])  * $signed({1'b0, y_r}));
          p2_r <= NumW'($signed(row1_r[63:32]) * $signed({1'b0, x_r}));
          p3_r <= NumW'($signed(row1_r[31:0])  * $signed({1'b0, y_r}));
          p4_r <= NumW'($signed(persp_r[63:32]) * $signed({1'b0, x_r}));
          p5_r <= NumW'($signed(persp_r[31:0])  * $signed({1'b0, y_r}));
        end
        S_SUM: begin
          nx_r  <= p0_r + p1_r + (NumW'($signed(trans_r[63:32])) <<< 12);
          ny_r  <= p2_r + p3_r + (NumW'($signed(trans_r[31:0])) <<< 12);
          den_r <= p4_r + p5_r + (NumW'($signed(scale_r)) <<< 6);
          step_r <= 6'h3f;
        end
        S_DIVX, S_DIVY: begin
          if (state_r == S_DIVX && den_r == '0) begin
            o_st_r <= ST_ZDEN;
          end else if (step_r == 6'h3f) begin
            // load the top of the dividend; the low QuotW bits are brought down later
            dd_r   <= d_abs << 1;
            rem_r  <= dvd_init >> QuotW;
            dvd_r  <= dvd_init;
            sat_r  <= (dvd_init >> QuotW) >= (d_abs << 1);
            q_r    <= '0;
            negx_r <= (((state_r == S_DIVX) ? nx_r[NumW-1] : ny_r[NumW-1]) ^ den_r[NumW-1]);
            step_r <= '0;
          end else if (!div_done) begin
            step_r <= step_r + 1'b1;
            rem_r  <= trial;
            dvd_r  <= dvd_r << 1;
            q_r    <= {q_r[QuotW-2:0], (shifted >= dd_r)};
          end else begin
            if (state_r == S_DIVX) px_r <= div_res; else py_r <= div_res;
            step_r <= 6'h3f;
            scan_r <= '0;
            lim_r  <= (32'(pcnt_r) > 32'(stored_r)) ? stored_r : SW'(pcnt_r);
          end
        end
        S_SCAN: begin
          rd_v_r <= (scan_r < lim_r) && !hit_r && !near;
          if (!scan_end) begin
            rd_i_r <= scan_r[AW-1:0]; scan_r <= scan_r + 1'b1;
          end else scan_r <= lim_r;
          if (near && !hit_r) begin hit_r <= 1'b1; hit_i_r <= rd_i_r; end
        end
        S_DRAIN: begin
          if (near && !hit_r) begin hit_r <= 1'b1; hit_i_r <= rd_i_r; end
          rd_v_r <= 1'b0;
        end
        S_OUT: begin
          ov_r <= 1'b1;
          if (func_r == FUNC_MATCH && o_st_r != ST_ZDEN) begin
            o_px_r <= px_r; o_py_r <= py_r; o_m_r <= hit_r;
            o_i_r <= hit_r ? IdxW'(hit_i_r) : '0;
            if (hit_r && pos_r != '1) pos_r <= pos_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.proj_x          = o_px_r;
  assign out_ch.proj_y          = o_py_r;
  assign out_ch.matched         = o_m_r;
  assign out_ch.match_index     = o_i_r;
  assign out_ch.positive_count  = pos_r;
  assign out_ch.evaluated_count = eval_r;
  assign out_ch.status          = o_st_r;

  a_noacc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ch.ready |=> ov_r) else $error("result dropped");
  a_store_cap: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= SW'(MAX_POINTS)) else $error("store overflow");
  a_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !o_m_r |-> o_i_r == '0) else $error("stray index");
endmodule
